>>> sv/spbm_pkg.sv
// Shared types and constants for the spectrum band level meter.
package spbm_pkg;

  localparam int NUM_BANDS        = 7;
  localparam int TABLE_BANDS      = 7;
  localparam int MAX_FRAME_LENGTH = 4096;
  localparam int BIN_WIDTH        = 24;

  localparam int RATE_W   = 18;
  localparam int FLEN_W   = 13;
  localparam int ALPHA_W  = 17;
  localparam int CFG_W    = 18;
  localparam int IDX_W    = 12;
  localparam int BAND_W   = 3;
  localparam int SUM_W    = 36;
  localparam int LEVEL_W  = 24;
  localparam int MAG_W    = BIN_WIDTH;
  localparam int RAD_W    = 2 * BIN_WIDTH;
  localparam int FREQ_W   = IDX_W + RATE_W;
  localparam int EDGE_W   = 31;
  localparam int PROD_W   = EDGE_W + FLEN_W + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] REG_SAMPLE_RATE  = 2'd0;
  localparam logic [1:0] REG_FRAME_LENGTH = 2'd1;
  localparam logic [1:0] REG_ALPHA        = 2'd2;

  localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(48000);
  localparam logic [FLEN_W-1:0]  FLEN_RESET  = FLEN_W'(512);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(6554);
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(65536);
  localparam logic [FLEN_W-1:0]  FLEN_MIN    = FLEN_W'(2);
  localparam logic [FLEN_W-1:0]  FLEN_MAX    = FLEN_W'(MAX_FRAME_LENGTH);

  localparam logic [EDGE_W-1:0] BAND_LO [TABLE_BANDS] = '{
    EDGE_W'(0), EDGE_W'(60), EDGE_W'(150), EDGE_W'(400),
    EDGE_W'(1000), EDGE_W'(2400), EDGE_W'(15000)
  };
  localparam logic [EDGE_W-1:0] BAND_HI [TABLE_BANDS] = '{
    EDGE_W'(60), EDGE_W'(150), EDGE_W'(400), EDGE_W'(1000),
    EDGE_W'(2400), EDGE_W'(15000), EDGE_W'(2147483647)
  };

  typedef struct packed {
    logic signed [BIN_WIDTH-1:0] bin_real;
    logic signed [BIN_WIDTH-1:0] bin_imag;
  } spbm_in_t;

  typedef struct packed {
    logic [BAND_W-1:0]  band_index;
    logic [LEVEL_W-1:0] band_level;
    logic [LEVEL_W-1:0] band_level_smoothed;
    logic               last_band;
  } spbm_out_t;

  typedef struct packed {
    logic [RATE_W-1:0]  sample_rate;
    logic [FLEN_W-1:0]  frame_n;
    logic [IDX_W-1:0]   half;
    logic [ALPHA_W-1:0] alpha;
  } spbm_cfg_t;

  typedef struct packed {
    logic signed [BIN_WIDTH-1:0] bin_real;
    logic signed [BIN_WIDTH-1:0] bin_imag;
    logic [IDX_W-1:0]            bin_idx;
    logic                        close;
  } spbm_job_t;

endpackage

>>> sv/spbm_front.sv
// Front end: takes bin requests, numbers them and marks the frame-closing bin.
module spbm_front import spbm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  spbm_in_t  in_data,
  input  spbm_cfg_t cfg,
  input  logic      q_full,
  output logic      q_push,
  output spbm_job_t q_data
);

  logic [IDX_W-1:0] bin_counter;
  logic [IDX_W-1:0] bin_counter_next;
  logic             close;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign close    = bin_counter >= cfg.half;

  always_comb begin
    q_data.bin_real = in_data.bin_real;
    q_data.bin_imag = in_data.bin_imag;
    q_data.bin_idx  = bin_counter;
    q_data.close    = close;
  end

  assign bin_counter_next = close ? '0 : bin_counter + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_counter <= '0;
    end else if (q_push) begin
      bin_counter <= bin_counter_next;
    end
  end

endmodule

>>> sv/spbm_queue.sv
// Short job queue between the front end and the back end.
module spbm_queue import spbm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  spbm_job_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      pop_valid,
  output spbm_job_t pop_data
);

  spbm_job_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign full      = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> pop_valid)
    else $error("queue pop while empty");

endmodule

>>> sv/spbm_back.sv
// Back end: magnitude, band accumulation, per-band divide, smoothing, result register.
module spbm_back import spbm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  spbm_cfg_t cfg,
  input  logic      q_valid,
  input  spbm_job_t q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output spbm_out_t out_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SQ1   = 4'd1;
  localparam logic [3:0] ST_SQ2   = 4'd2;
  localparam logic [3:0] ST_ROOT  = 4'd3;
  localparam logic [3:0] ST_ACC   = 4'd4;
  localparam logic [3:0] ST_DLOAD = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_MUL1  = 4'd7;
  localparam logic [3:0] ST_MUL2  = 4'd8;
  localparam logic [3:0] ST_SUM   = 4'd9;
  localparam logic [3:0] ST_EMIT  = 4'd10;

  localparam int ROOT_STEPS = BIN_WIDTH / 2;
  localparam int STEP_W     = $clog2(ROOT_STEPS);
  localparam int DCNT_W     = $clog2(SUM_W);
  localparam int MUL_W      = ALPHA_W + LEVEL_W;
  localparam int ACC_W      = MUL_W + 1;
  localparam int SHR_W      = ACC_W - 16;

  typedef struct packed {
    logic [RAD_W-1:0] x;
    logic [RAD_W-1:0] r;
    logic [RAD_W-1:0] b;
  } root_t;

  function automatic root_t root_step(root_t s);
    root_t o;
    o = s;
    if (s.x >= s.r + s.b) begin
      o.x = s.x - (s.r + s.b);
      o.r = (s.r >> 1) + s.b;
    end else begin
      o.r = s.r >> 1;
    end
    o.b = s.b >> 2;
    return o;
  endfunction

  logic [3:0]             state;
  logic [MAG_W-1:0]       abs_re;
  logic [MAG_W-1:0]       abs_im;
  logic [IDX_W-1:0]       bin_idx;
  logic                   close;
  logic [RAD_W-1:0]       sq;
  logic [FREQ_W-1:0]      freq;
  root_t                  root;
  logic [STEP_W-1:0]      step;
  logic [NUM_BANDS-1:0]   hit;
  logic [SUM_W-1:0]       sums [NUM_BANDS];
  logic [LEVEL_W-1:0]     smooth [NUM_BANDS];
  logic [BAND_W-1:0]      band;
  logic [SUM_W-1:0]       dq;
  logic [IDX_W-1:0]       rem;
  logic [DCNT_W-1:0]      dcnt;
  logic [MUL_W-1:0]       p1;
  logic [MUL_W-1:0]       p2;
  logic [LEVEL_W-1:0]     lvl;
  logic [LEVEL_W-1:0]     sm;

  root_t                  root_next;
  logic [NUM_BANDS-1:0]   hit_next;
  logic [IDX_W-1:0]       divisor;
  logic [IDX_W:0]         trial;
  logic                   qbit;
  logic [LEVEL_W-1:0]     lvl_sat;
  logic [ACC_W-1:0]       total;
  logic [SHR_W-1:0]       shifted;
  logic                   emit_go;
  logic                   last;

  assign q_pop   = state == ST_IDLE && q_valid;
  assign emit_go = !out_valid || out_ready;
  assign last    = band == BAND_W'(NUM_BANDS - 1);
  assign divisor = cfg.half + IDX_W'(1);
  assign trial   = {rem, dq[SUM_W-1]};
  assign qbit    = trial >= {1'b0, divisor};
  assign lvl_sat = (|dq[SUM_W-1:LEVEL_W]) ? '1 : dq[LEVEL_W-1:0];
  assign total   = ACC_W'(p1) + ACC_W'(p2) + ACC_W'(32768);
  assign shifted = total[ACC_W-1:16];

  always_comb begin
    root_next = root_step(root_step(root));
  end

  always_comb begin
    hit_next = '0;
    for (int b = 0; b < NUM_BANDS; b++) begin
      if (b < TABLE_BANDS) begin
        hit_next[b] = (PROD_W'(BAND_LO[b]) * PROD_W'(cfg.frame_n) < PROD_W'(freq)) &&
                      (PROD_W'(freq) <= PROD_W'(BAND_HI[b]) * PROD_W'(cfg.frame_n));
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        abs_re  <= q_data.bin_real[BIN_WIDTH-1] ? MAG_W'(-q_data.bin_real)
                                                : MAG_W'(q_data.bin_real);
        abs_im  <= q_data.bin_imag[BIN_WIDTH-1] ? MAG_W'(-q_data.bin_imag)
                                                : MAG_W'(q_data.bin_imag);
        bin_idx <= q_data.bin_idx;
        close   <= q_data.close;
      end
      ST_SQ1: begin
        sq   <= RAD_W'(abs_re) * RAD_W'(abs_re);
        freq <= FREQ_W'(bin_idx) * FREQ_W'(cfg.sample_rate);
      end
      ST_SQ2: begin
        root.x <= sq + RAD_W'(abs_im) * RAD_W'(abs_im);
        root.r <= '0;
        root.b <= RAD_W'(1) << (RAD_W - 2);
        hit    <= hit_next;
      end
      ST_ROOT: begin
        root <= root_next;
      end
      ST_DLOAD: begin
        dq  <= sums[band];
        rem <= '0;
      end
      ST_DIV: begin
        rem <= qbit ? IDX_W'(trial - {1'b0, divisor}) : IDX_W'(trial);
        dq  <= {dq[SUM_W-2:0], qbit};
      end
      ST_MUL1: begin
        lvl <= lvl_sat;
        p1  <= MUL_W'(cfg.alpha) * MUL_W'(lvl_sat);
      end
      ST_MUL2: begin
        p2 <= MUL_W'(ALPHA_ONE - cfg.alpha) * MUL_W'(smooth[band]);
      end
      ST_SUM: begin
        sm <= (|shifted[SHR_W-1:LEVEL_W]) ? '1 : shifted[LEVEL_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && emit_go) begin
      out_data.band_index          <= band;
      out_data.band_level          <= lvl;
      out_data.band_level_smoothed <= sm;
      out_data.last_band           <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      dcnt      <= '0;
      band      <= '0;
      out_valid <= 1'b0;
      for (int b = 0; b < NUM_BANDS; b++) begin
        sums[b]   <= '0;
        smooth[b] <= '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_SQ1;
          end
        end
        ST_SQ1: begin
          state <= ST_SQ2;
        end
        ST_SQ2: begin
          step  <= '0;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(ROOT_STEPS - 1)) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          for (int b = 0; b < NUM_BANDS; b++) begin
            if (hit[b]) begin
              sums[b] <= (&sums[b]) ? sums[b]
                       : ((SUM_W+1)'(sums[b]) + (SUM_W+1)'(root.r[MAG_W-1:0]) > (SUM_W+1)'({SUM_W{1'b1}}))
                         ? '1 : sums[b] + SUM_W'(root.r[MAG_W-1:0]);
            end
          end
          band  <= '0;
          state <= close ? ST_DLOAD : ST_IDLE;
        end
        ST_DLOAD: begin
          dcnt  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          dcnt <= dcnt + DCNT_W'(1);
          if (dcnt == DCNT_W'(SUM_W - 1)) begin
            state <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          state <= ST_SUM;
        end
        ST_SUM: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_valid    <= 1'b1;
            smooth[band] <= sm;
            sums[band]   <= '0;
            if (last) begin
              state <= ST_IDLE;
            end else begin
              band  <= band + BAND_W'(1);
              state <= ST_DLOAD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_last_tag: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_data.last_band) |-> out_data.band_index == BAND_W'(NUM_BANDS - 1))
    else $error("last_band on a band other than the final one");
  a_frame_done: assert property (@(posedge clk) disable iff (rst)
      (state == ST_EMIT && emit_go && last) |=> state == ST_IDLE && out_valid)
    else $error("frame close did not return to idle with a result");
  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
      (state == ST_EMIT && emit_go && band == '0) |=> sums[0] == '0)
    else $error("band sum not cleared after its result");

endmodule

>>> sv/spectrum_band_level_meter_top.sv
// Top level: configuration registers, front end, job queue and back end.
// Front end takes one bin request per cycle while the two-entry queue has room.
// Back end takes a new bin only when idle; its serial square root works two bits a cycle.
// The frame-closing bin then adds, per band, a serial divide, two multiplies, a sum and an emit.
// Synchronous reset restores default configuration and clears counters, sums and levels.
module spectrum_band_level_meter_top import spbm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  spbm_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output spbm_out_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [RATE_W-1:0]  sample_rate;
  logic [FLEN_W-1:0]  frame_length;
  logic [ALPHA_W-1:0] smoothing_alpha;
  spbm_cfg_t          cfg;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  spbm_job_t push_data;
  spbm_job_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate     <= RATE_RESET;
      frame_length    <= FLEN_RESET;
      smoothing_alpha <= ALPHA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_RATE:  sample_rate     <= cfg_data[RATE_W-1:0];
        REG_FRAME_LENGTH: frame_length    <= cfg_data[FLEN_W-1:0];
        REG_ALPHA:        smoothing_alpha <= cfg_data[ALPHA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.sample_rate = sample_rate;
    if (frame_length < FLEN_MIN) begin
      cfg.frame_n = FLEN_MIN;
    end else if (frame_length > FLEN_MAX) begin
      cfg.frame_n = FLEN_MAX;
    end else begin
      cfg.frame_n = frame_length;
    end
    cfg.half  = cfg.frame_n[FLEN_W-1:1];
    cfg.alpha = (smoothing_alpha > ALPHA_ONE) ? ALPHA_ONE : smoothing_alpha;
  end

  spbm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  spbm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (pop_data)
  );

  spbm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
